@@ hw/rtl/tepha_pkg.sv @@
// ---------------------------------------------------------------------------
// tepha_pkg: shared types and constants of the edge-product Heron area block
// Widths of the coordinate, edge, product and area paths, and the records
// that pass between the front part, the middle queue and the back part.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tepha_pkg;

  // Input coordinates.
  localparam int COORD_W   = 12;
  localparam int NUM_COORD = 12;
  localparam int DIFF_W    = COORD_W + 1;

  // Edge lengths: squared distance, then Q8 root of d2 * 2^16.
  localparam int NUM_EDGE   = 6;
  localparam int SQ_W       = 24;
  localparam int D2_W       = 26;
  localparam int EDGE_SHIFT = 16;
  localparam int EDGE_W     = 21;

  // Opposite edge products and Heron factors.
  localparam int NUM_PROD = 3;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int FAC_W    = PROD_W + 1;
  localparam int SUM_W    = PROD_W + 2;

  // Four-factor product and area root.
  localparam int MA_W       = SUM_W;
  localparam int PA_W       = 2 * MA_W;
  localparam int PB_W       = 2 * PA_W;
  localparam int PEXT_W     = PB_W + 4;
  localparam int AREA_W     = 54;
  localparam int RAD_W      = 2 * AREA_W;
  localparam int SHIFT_BASE = 68;

  // Multiplier slice width; one slice product stays within 32 by 32 bits.
  localparam int MUL_CHUNK = 29;

  // Queues.
  localparam int MID_DEPTH = 32;
  localparam int OUT_DEPTH = 64;
  localparam int CNT_W     = 8;

  // Record passed from the front part to the back part.
  typedef struct packed {
    logic               deg;
    logic [SUM_W-1:0]   sum;
    logic [FAC_W-1:0]   fac2;
    logic [FAC_W-1:0]   fac3;
    logic [FAC_W-1:0]   fac4;
  } tepha_mid_t;

  // Status a queue reports to its consumer and producer.
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } tepha_fifo_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/tepha_sqrt.sv @@
// ---------------------------------------------------------------------------
// tepha_sqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per stage, K stages, over
// LANES independent radicands that share one sideband word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tepha_sqrt #(
  parameter int K     = 21,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [LANES-1:0][2*K-1:0]   rad,
  input  wire logic [SW-1:0]               side_in,
  output logic      [LANES-1:0][K-1:0]     root,
  output logic      [SW-1:0]               side_out
);

  // Stage registers; index zero is the stage input.
  logic [LANES-1:0][K:0]     rem_d  [0:K];
  logic [LANES-1:0][K-1:0]   root_d [0:K];
  logic [LANES-1:0][2*K-1:0] rad_d  [0:K];
  logic [SW-1:0]             side_d [0:K];

  assign rem_d[0]  = '0;
  assign root_d[0] = '0;
  assign rad_d[0]  = rad;
  assign side_d[0] = side_in;

  for (genvar s = 0; s < K; s++) begin : g_stage
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [K+2:0] cur;
      logic [K+2:0] trial;
      logic         ge;

      // Bring down two radicand bits and try the next root bit.
      assign cur   = {rem_d[s][l], rad_d[s][l][2*K-1 -: 2]};
      assign trial = {1'b0, root_d[s][l], 2'b01};
      assign ge    = (cur >= trial);

      always_ff @(posedge clk) begin
        rem_d[s+1][l]  <= ge ? (K+1)'(cur - trial) : cur[K:0];
        root_d[s+1][l] <= {root_d[s][l][K-2:0], ge};
        rad_d[s+1][l]  <= rad_d[s][l] << 2;
      end
    end

    // Sideband carries the valid bit, so it is reset.
    always_ff @(posedge clk) begin
      if (rst) begin
        side_d[s+1] <= '0;
      end else begin
        side_d[s+1] <= side_d[s];
      end
    end
  end

  assign root     = root_d[K];
  assign side_out = side_d[K];

endmodule

`default_nettype wire

@@ hw/rtl/tepha_mul.sv @@
// ---------------------------------------------------------------------------
// tepha_mul: pipelined sliced multiplier
// Slice products in stage one, row sums in stage two, final sum in stage
// three, over LANES independent operand pairs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tepha_mul #(
  parameter int WA    = 21,
  parameter int WB    = 21,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [LANES-1:0][WA-1:0]     a,
  input  wire logic [LANES-1:0][WB-1:0]     b,
  input  wire logic [SW-1:0]                side_in,
  output logic      [LANES-1:0][WA+WB-1:0]  p,
  output logic      [SW-1:0]                side_out
);

  localparam int C  = tepha_pkg::MUL_CHUNK;
  localparam int NA = (WA + C - 1) / C;
  localparam int NB = (WB + C - 1) / C;
  localparam int AP = NA * C;
  localparam int BP = NB * C;

  logic [LANES-1:0][AP-1:0] a_ext;
  logic [LANES-1:0][BP-1:0] b_ext;
  logic [2*C-1:0]           pp_q  [LANES][NA][NB];
  logic [AP+C-1:0]          row_n [LANES][NB];
  logic [AP+C-1:0]          row_q [LANES][NB];
  logic [AP+BP-1:0]         prod_n [LANES];
  logic [AP+BP-1:0]         prod_q [LANES];
  logic [SW-1:0]            side_q [3];

  for (genvar l = 0; l < LANES; l++) begin : g_ext
    assign a_ext[l] = AP'(a[l]);
    assign b_ext[l] = BP'(b[l]);
    assign p[l]     = prod_q[l][WA+WB-1:0];
  end

  // Stage one: slice products.
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[l][i][j] <= a_ext[l][i*C +: C] * b_ext[l][j*C +: C];
        end
      end
    end
  end

  // Stage two: one row per slice of b.
  always_comb begin
    logic [AP+C-1:0] acc;
    for (int l = 0; l < LANES; l++) begin
      for (int j = 0; j < NB; j++) begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
          acc = acc + ((AP+C)'(pp_q[l][i][j]) << (i*C));
        end
        row_n[l][j] = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_q  <= row_n;
    prod_q <= prod_n;
  end

  // Stage three: rows into the full product.
  always_comb begin
    logic [AP+BP-1:0] acc;
    for (int l = 0; l < LANES; l++) begin
      acc = '0;
      for (int j = 0; j < NB; j++) begin
        acc = acc + ((AP+BP)'(row_q[l][j]) << (j*C));
      end
      prod_n[l] = acc;
    end
  end

  // Sideband follows the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_q[0] <= '0;
      side_q[1] <= '0;
      side_q[2] <= '0;
    end else begin
      side_q[0] <= side_in;
      side_q[1] <= side_q[0];
      side_q[2] <= side_q[1];
    end
  end

  assign side_out = side_q[2];

endmodule

`default_nettype wire

@@ hw/rtl/tepha_fifo.sv @@
// ---------------------------------------------------------------------------
// tepha_fifo: show-ahead queue
// A memory with a registered read that fills an output register; reports
// the held count so a producer can reserve room before it issues.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tepha_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire logic [W-1:0]                  din,
  input  wire logic                          pop,
  output logic      [W-1:0]                  dout,
  output tepha_pkg::tepha_fifo_stat_t        stat
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   mem_cnt;
  logic          out_valid;
  logic          pop_ok;
  logic          load;

  assign pop_ok = pop && out_valid;
  assign load   = (mem_cnt != '0) && (!out_valid || pop_ok);

  // Memory write and registered read into the output register.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
    if (load) begin
      dout <= mem[rptr];
    end
  end

  // Pointers, fill count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= '0;
      rptr      <= '0;
      mem_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (load) begin
        rptr <= rptr + 1'b1;
      end
      mem_cnt <= mem_cnt + (AW+1)'(push) - (AW+1)'(load);
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop_ok) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.valid = out_valid;
  assign stat.count = tepha_pkg::CNT_W'(mem_cnt) + tepha_pkg::CNT_W'(out_valid);

endmodule

`default_nettype wire

@@ hw/rtl/tepha_front.sv @@
// ---------------------------------------------------------------------------
// tepha_front: edge lengths, opposite products and classification
// Accepts corner requests, finds the Q8 edge lengths, multiplies opposite
// pairs, forms the Heron factors and flags flat triangles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tepha_front #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                                      clk,
  input  wire logic                                                      rst,
  input  wire logic                                                      push,
  output logic                                                           full,
  input  wire logic [tepha_pkg::NUM_COORD-1:0][tepha_pkg::COORD_W-1:0]   coord,
  output logic                                                           mid_push,
  output tepha_pkg::tepha_mid_t                                          mid_data,
  input  wire tepha_pkg::tepha_fifo_stat_t                               mid_stat
);

  localparam int SH = tepha_pkg::COORD_W - COORD_BITS;
  localparam int NE = tepha_pkg::NUM_EDGE;
  localparam int EW = tepha_pkg::EDGE_W;
  localparam int PW = tepha_pkg::PROD_W;

  // Corner pairs of the edges p, q, r, a, b, c.
  localparam int EP0 [NE] = '{0, 0, 0, 2, 3, 1};
  localparam int EP1 [NE] = '{1, 2, 3, 3, 1, 2};

  logic                                     accept;
  logic [tepha_pkg::CNT_W-1:0]              inflight;
  logic signed [tepha_pkg::COORD_W-1:0]     sx [tepha_pkg::NUM_COORD];
  logic [tepha_pkg::SQ_W-1:0]               sq_next [NE][3];
  logic [tepha_pkg::SQ_W-1:0]               sq_q    [NE][3];
  logic                                     v1;
  logic [NE-1:0][2*EW-1:0]                  rad_q;
  logic                                     v2;
  logic [NE-1:0][EW-1:0]                    edges;
  logic                                     vs;
  logic [tepha_pkg::NUM_PROD-1:0][EW-1:0]   ma;
  logic [tepha_pkg::NUM_PROD-1:0][EW-1:0]   mb;
  logic [tepha_pkg::NUM_PROD-1:0][PW-1:0]   prods;
  logic                                     vm;
  logic [PW:0]                              fg;
  logic [PW:0]                              eg;
  logic [PW:0]                              ef;

  // Reserve a queue slot for every request in flight.
  assign full   = (inflight + mid_stat.count) >= tepha_pkg::CNT_W'(tepha_pkg::MID_DEPTH);
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + tepha_pkg::CNT_W'(accept) - tepha_pkg::CNT_W'(mid_push);
    end
  end

  // Sign-extend the low COORD_BITS bits of each coordinate.
  always_comb begin
    logic [tepha_pkg::COORD_W-1:0] shifted;
    for (int k = 0; k < tepha_pkg::NUM_COORD; k++) begin
      shifted = coord[k] << SH;
      sx[k]   = $signed(shifted) >>> SH;
    end
  end

  // Axis differences and their squares.
  always_comb begin
    logic signed [tepha_pkg::DIFF_W-1:0]   d;
    logic signed [2*tepha_pkg::DIFF_W-1:0] pr;
    for (int e = 0; e < NE; e++) begin
      for (int ax = 0; ax < 3; ax++) begin
        d  = tepha_pkg::DIFF_W'(sx[EP0[e]*3 + ax]) - tepha_pkg::DIFF_W'(sx[EP1[e]*3 + ax]);
        pr = d * d;
        sq_next[e][ax] = pr[tepha_pkg::SQ_W-1:0];
      end
    end
  end

  // Stage one holds the squares, stage two the scaled squared distances.
  always_ff @(posedge clk) begin
    logic [tepha_pkg::D2_W-1:0] d2;
    sq_q <= sq_next;
    for (int e = 0; e < NE; e++) begin
      d2 = tepha_pkg::D2_W'(sq_q[e][0]) + tepha_pkg::D2_W'(sq_q[e][1])
         + tepha_pkg::D2_W'(sq_q[e][2]);
      rad_q[e] <= {d2, {tepha_pkg::EDGE_SHIFT{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  // Edge roots, one per parallel lane.
  tepha_sqrt #(
    .K     (EW),
    .LANES (NE),
    .SW    (1)
  ) u_edge_sqrt (
    .clk      (clk),
    .rst      (rst),
    .rad      (rad_q),
    .side_in  (v2),
    .root     (edges),
    .side_out (vs)
  );

  // Opposite pairs: a*p, b*q, c*r.
  assign ma[0] = edges[3];
  assign mb[0] = edges[0];
  assign ma[1] = edges[4];
  assign mb[1] = edges[1];
  assign ma[2] = edges[5];
  assign mb[2] = edges[2];

  tepha_mul #(
    .WA    (EW),
    .WB    (EW),
    .LANES (tepha_pkg::NUM_PROD),
    .SW    (1)
  ) u_edge_mul (
    .clk      (clk),
    .rst      (rst),
    .a        (ma),
    .b        (mb),
    .side_in  (vs),
    .p        (prods),
    .side_out (vm)
  );

  // Heron factors and the flat-triangle flag.
  assign fg = (PW+1)'(prods[1]) + (PW+1)'(prods[2]);
  assign eg = (PW+1)'(prods[0]) + (PW+1)'(prods[2]);
  assign ef = (PW+1)'(prods[0]) + (PW+1)'(prods[1]);

  always_ff @(posedge clk) begin
    mid_data.deg  <= (fg <= (PW+1)'(prods[0])) || (eg <= (PW+1)'(prods[1]))
                  || (ef <= (PW+1)'(prods[2]));
    mid_data.sum  <= tepha_pkg::SUM_W'(fg) + tepha_pkg::SUM_W'(prods[0]);
    mid_data.fac2 <= fg - (PW+1)'(prods[0]);
    mid_data.fac3 <= eg - (PW+1)'(prods[1]);
    mid_data.fac4 <= ef - (PW+1)'(prods[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_push <= 1'b0;
    end else begin
      mid_push <= vm;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tepha_back.sv @@
// ---------------------------------------------------------------------------
// tepha_back: four-factor product, scaling and area root
// Takes classified requests from the middle queue, multiplies the Heron
// factors, scales, saturates, takes the root and queues the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tepha_back #(
  parameter int AREA_FRAC_BITS = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tepha_pkg::tepha_mid_t               mid_data,
  input  wire tepha_pkg::tepha_fifo_stat_t         mid_stat,
  output logic                                     mid_pop,
  input  wire logic                                pop,
  output logic                                     empty,
  output logic [tepha_pkg::AREA_W-1:0]             area_q4
);

  localparam int SHIFT = tepha_pkg::SHIFT_BASE - 2 * AREA_FRAC_BITS;
  localparam int MW    = tepha_pkg::MA_W;
  localparam int AW    = tepha_pkg::AREA_W;

  logic                                 issue;
  logic [tepha_pkg::CNT_W-1:0]          inflight;
  tepha_pkg::tepha_fifo_stat_t          out_stat;
  logic [1:0][MW-1:0]                   ma;
  logic [1:0][MW-1:0]                   mb;
  logic [1:0][tepha_pkg::PA_W-1:0]      pa;
  logic [1:0]                           side_a;
  logic [0:0][tepha_pkg::PB_W-1:0]      pb;
  logic [1:0]                           side_b;
  logic [tepha_pkg::PEXT_W-1:0]         pext;
  logic                                 sat;
  logic [0:0][tepha_pkg::RAD_W-1:0]     rad;
  logic [0:0][AW-1:0]                   root;
  logic [2:0]                           side_r;
  logic [AW-1:0]                        res;

  // Issue from the middle queue only with room reserved at the output.
  assign issue   = mid_stat.valid
                && ((inflight + out_stat.count) < tepha_pkg::CNT_W'(tepha_pkg::OUT_DEPTH));
  assign mid_pop = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + tepha_pkg::CNT_W'(issue) - tepha_pkg::CNT_W'(side_r[0]);
    end
  end

  // First level: sum * fac2 and fac3 * fac4.
  assign ma[0] = mid_data.sum;
  assign mb[0] = MW'(mid_data.fac2);
  assign ma[1] = MW'(mid_data.fac3);
  assign mb[1] = MW'(mid_data.fac4);

  tepha_mul #(
    .WA    (MW),
    .WB    (MW),
    .LANES (2),
    .SW    (2)
  ) u_mul_a (
    .clk      (clk),
    .rst      (rst),
    .a        (ma),
    .b        (mb),
    .side_in  ({mid_data.deg, issue}),
    .p        (pa),
    .side_out (side_a)
  );

  // Second level: the full Heron product.
  tepha_mul #(
    .WA    (tepha_pkg::PA_W),
    .WB    (tepha_pkg::PA_W),
    .LANES (1),
    .SW    (2)
  ) u_mul_b (
    .clk      (clk),
    .rst      (rst),
    .a        (pa[0]),
    .b        (pa[1]),
    .side_in  (side_a),
    .p        (pb),
    .side_out (side_b)
  );

  // Scale to the area fraction and flag a root that would overflow.
  assign pext   = tepha_pkg::PEXT_W'(pb[0]);
  assign rad[0] = pext[SHIFT +: tepha_pkg::RAD_W];
  assign sat    = |pext[tepha_pkg::PEXT_W-1 : SHIFT + tepha_pkg::RAD_W];

  tepha_sqrt #(
    .K     (AW),
    .LANES (1),
    .SW    (3)
  ) u_area_sqrt (
    .clk      (clk),
    .rst      (rst),
    .rad      (rad),
    .side_in  ({sat, side_b}),
    .root     (root),
    .side_out (side_r)
  );

  // Flat triangles give zero; an oversized root saturates.
  always_comb begin
    if (side_r[1]) begin
      res = '0;
    end else if (side_r[2]) begin
      res = '1;
    end else begin
      res = root[0];
    end
  end

  tepha_fifo #(
    .W     (AW),
    .DEPTH (tepha_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (side_r[0]),
    .din  (res),
    .pop  (pop),
    .dout (area_q4),
    .stat (out_stat)
  );

  assign empty = !out_stat.valid;

endmodule

`default_nettype wire

@@ hw/rtl/tetra_edge_product_heron_area.sv @@
// ---------------------------------------------------------------------------
// tetra_edge_product_heron_area: Heron area of a tetrahedron's edge products
// Top level: front part, middle queue and back part.
// ---------------------------------------------------------------------------
// Usage:
// The input side is a queue write port: a request of twelve corner
// coordinates is taken on a clock edge with push high and full low.
// The result side is a queue read port: while empty is low, area_q4 shows
// the oldest result, and it is removed on an edge with pop high.
// A new request can be taken every cycle while full is low. A request
// passes the front pipeline (two input stages, a 21-stage edge root, a
// 3-stage multiplier, one factor stage), the middle queue and the back
// pipeline (two 3-stage multipliers and a 54-stage area root), and its
// result is then read through the output queue.
// Full rises when the requests in flight fill the reserved queue room; a
// receiver that stops popping therefore stalls the input once about 96
// requests are held (64 in the back part and its output queue, 32 in the
// front part and the middle queue), and nothing is dropped. Reset empties
// both queues and all pipeline valid bits; no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tetra_edge_product_heron_area #(
  parameter int COORD_BITS     = 12,
  parameter int AREA_FRAC_BITS = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [tepha_pkg::COORD_W-1:0]     ax,
  input  wire logic [tepha_pkg::COORD_W-1:0]     ay,
  input  wire logic [tepha_pkg::COORD_W-1:0]     az,
  input  wire logic [tepha_pkg::COORD_W-1:0]     bx,
  input  wire logic [tepha_pkg::COORD_W-1:0]     by_coord,
  input  wire logic [tepha_pkg::COORD_W-1:0]     bz,
  input  wire logic [tepha_pkg::COORD_W-1:0]     cx,
  input  wire logic [tepha_pkg::COORD_W-1:0]     cy,
  input  wire logic [tepha_pkg::COORD_W-1:0]     cz,
  input  wire logic [tepha_pkg::COORD_W-1:0]     dx,
  input  wire logic [tepha_pkg::COORD_W-1:0]     dy,
  input  wire logic [tepha_pkg::COORD_W-1:0]     dz,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [tepha_pkg::AREA_W-1:0]           area_q4
);

  logic [tepha_pkg::NUM_COORD-1:0][tepha_pkg::COORD_W-1:0] coord;
  logic                                                    mid_push;
  tepha_pkg::tepha_mid_t                                   mid_in;
  tepha_pkg::tepha_mid_t                                   mid_out;
  tepha_pkg::tepha_fifo_stat_t                             mid_stat;
  logic                                                    mid_pop;

  // Corner zero x sits at index zero.
  assign coord = {dz, dy, dx, cz, cy, cx, bz, by_coord, bx, az, ay, ax};

  // Front part: edges, products and classification.
  tepha_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .coord    (coord),
    .mid_push (mid_push),
    .mid_data (mid_in),
    .mid_stat (mid_stat)
  );

  // Middle queue lets each side stall on its own.
  tepha_fifo #(
    .W     ($bits(tepha_pkg::tepha_mid_t)),
    .DEPTH (tepha_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (mid_push),
    .din  (mid_in),
    .pop  (mid_pop),
    .dout (mid_out),
    .stat (mid_stat)
  );

  // Back part: product, root and output queue.
  tepha_back #(
    .AREA_FRAC_BITS (AREA_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .mid_data (mid_out),
    .mid_stat (mid_stat),
    .mid_pop  (mid_pop),
    .pop      (pop),
    .empty    (empty),
    .area_q4  (area_q4)
  );

endmodule

`default_nettype wire

@@ hw/rtl/tepha_checker.sv @@
// ---------------------------------------------------------------------------
// tepha_checker: port-level checks of the area block
// Tracks requests held inside the block and checks results and flow
// control against that count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tepha_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        push,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [53:0] area_q4
);

  logic [7:0] held;

  // Requests taken minus results removed.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else begin
      held <= held + 8'(push && !full) - 8'(pop && !empty);
    end
  end

  // Reset leaves no result waiting and the input open.
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("block not idle after reset");

  // A result is never shown without a request behind it.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (held != 8'd0))
    else $error("result shown with no request held");

  // Full only when requests are held.
  a_full_held: assert property (@(posedge clk) disable iff (rst)
    full |-> (held != 8'd0))
    else $error("full with nothing held");

  // A stalled result stays put.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(area_q4)))
    else $error("stalled result changed");

endmodule

bind tetra_edge_product_heron_area tepha_checker u_chk (.*);

`default_nettype wire
